// ----- rtl/bhpq_pkg.sv -----
// Shared types, constants and codes for the binary heap priority queue.
`timescale 1ns / 1ps
package bhpq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int ID_W         = 16;
    localparam int PRIO_W       = 32;
    localparam int OCC_W        = 11;
    localparam int STAT_W       = 2;
    localparam int ENTRY_W      = ID_W + PRIO_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   item_id;
        logic [PRIO_W-1:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   top_id;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SU_RD,
        S_SU_CMP,
        S_POP_LAST,
        S_POP_LOAD,
        S_SD_CHK,
        S_SD_RDR,
        S_SD_CMP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic ins_load;
        logic ins_drop;
        logic pop_empty;
        logic pop_root;
        logic pop_last;
        logic pop_load;
        logic su_rd;
        logic su_cmp;
        logic sd_chk;
        logic sd_rdr;
        logic sd_cmp;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic pos_root;
        logic no_child;
        logic su_swap;
        logic sd_swap;
    } t_dp_status;

endpackage

// ----- rtl/bhpq_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bhpq_ctrl.sv -----
// Sequencer for insert sift-up and pop sift-down.
`timescale 1ns / 1ps
module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_req_type,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == REQ_INSERT) begin
                        n_state = i_status.full ? S_RESP : S_SU_RD;
                    end else begin
                        n_state = i_status.empty ? S_RESP : S_POP_LAST;
                    end
                end
            end
            S_SU_RD:    n_state = i_status.pos_root ? S_RESP : S_SU_CMP;
            S_SU_CMP:   n_state = i_status.su_swap ? S_SU_RD : S_RESP;
            S_POP_LAST: n_state = S_POP_LOAD;
            S_POP_LOAD: n_state = i_status.last_one ? S_RESP : S_SD_CHK;
            S_SD_CHK:   n_state = i_status.no_child ? S_RESP : S_SD_RDR;
            S_SD_RDR:   n_state = S_SD_CMP;
            S_SD_CMP:   n_state = i_status.sd_swap ? S_SD_CHK : S_RESP;
            S_RESP:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_req_type == REQ_INSERT) begin
                        o_cmd.ins_load = !i_status.full;
                        o_cmd.ins_drop = i_status.full;
                    end else begin
                        o_cmd.pop_root  = !i_status.empty;
                        o_cmd.pop_empty = i_status.empty;
                    end
                end
            end
            S_SU_RD:    o_cmd.su_rd    = 1'b1;
            S_SU_CMP:   o_cmd.su_cmp   = 1'b1;
            S_POP_LAST: o_cmd.pop_last = 1'b1;
            S_POP_LOAD: o_cmd.pop_load = 1'b1;
            S_SD_CHK:   o_cmd.sd_chk   = 1'b1;
            S_SD_RDR:   o_cmd.sd_rdr   = 1'b1;
            S_SD_CMP:   o_cmd.sd_cmp   = 1'b1;
            S_RESP:     o_done         = 1'b1;
            default:    o_busy         = 1'b1;
        endcase
    end

endmodule

// ----- rtl/bhpq_dpath.sv -----
// Heap datapath: entry memory, count, position and compare logic.
`timescale 1ns / 1ps
module bhpq_dpath
    import bhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  t_req       i_req,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_rsp       o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic              r_order_min;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_pos;
    t_entry            r_cur;
    t_entry            r_left;
    logic              r_left_better;
    logic [STAT_W-1:0] r_stat;
    logic [ID_W-1:0]   r_top;

    t_entry            rdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;

    logic [CW-1:0]     pos_m1;
    logic [CW-1:0]     parent;
    logic [CW-1:0]     parent_m1;
    logic [CW-1:0]     count_m1;
    logic [CW:0]       child;
    logic [CW:0]       child_m1;
    logic              has_right;
    logic              pick_right;
    logic              rd_vs_cur;
    logic              right_vs_left;
    logic              right_vs_cur;
    logic [CW+OCC_W-1:0] occ_ext;

    function automatic logic better(input logic order_min,
                                    input logic [PRIO_W-1:0] a,
                                    input logic [PRIO_W-1:0] b);
        return order_min ? (a < b) : (a > b);
    endfunction

    bhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rdata     = t_entry'(ram_rdata);
    assign pos_m1    = r_pos - CW'(1);
    assign parent    = r_pos >> 1;
    assign parent_m1 = parent - CW'(1);
    assign count_m1  = r_count - CW'(1);
    assign child     = {r_pos, 1'b0};
    assign child_m1  = child - (CW+1)'(1);
    assign has_right = child < {1'b0, r_count};

    assign rd_vs_cur     = better(r_order_min, rdata.prio, r_cur.prio);
    assign right_vs_left = better(r_order_min, rdata.prio, r_left.prio);
    assign right_vs_cur  = rd_vs_cur;
    assign pick_right    = has_right && right_vs_left;

    always_comb begin
        o_status.full     = r_count >= CW'(CAPACITY);
        o_status.empty    = r_count == '0;
        o_status.last_one = r_count == CW'(1);
        o_status.pos_root = r_pos == CW'(1);
        o_status.no_child = child > {1'b0, r_count};
        o_status.su_swap  = better(r_order_min, r_cur.prio, rdata.prio);
        o_status.sd_swap  = pick_right ? right_vs_cur : r_left_better;
    end

    // Memory port steering per command.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_m1[AW-1:0];
        ram_wdata = r_cur;
        ram_re    = 1'b0;
        ram_raddr = parent_m1[AW-1:0];
        case (1'b1)
            i_cmd.pop_root: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            i_cmd.pop_last: begin
                ram_re    = 1'b1;
                ram_raddr = count_m1[AW-1:0];
            end
            i_cmd.su_rd: begin
                ram_we = o_status.pos_root;
                ram_re = !o_status.pos_root;
            end
            i_cmd.su_cmp: begin
                ram_we    = 1'b1;
                ram_wdata = o_status.su_swap ? rdata : r_cur;
            end
            i_cmd.sd_chk: begin
                ram_we    = o_status.no_child;
                ram_re    = !o_status.no_child;
                ram_raddr = child_m1[AW-1:0];
            end
            i_cmd.sd_rdr: begin
                ram_re    = 1'b1;
                ram_raddr = child[AW-1:0];
            end
            i_cmd.sd_cmp: begin
                ram_we = 1'b1;
                if (o_status.sd_swap) begin
                    ram_wdata = pick_right ? rdata : r_left;
                end
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_min <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_order_min <= i_cfg_wdata;
            end
            if (i_cmd.ins_load) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_load) begin
                r_count <= count_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_load) begin
            r_pos  <= r_count + CW'(1);
            r_cur  <= '{id: i_req.item_id, prio: i_req.item_priority};
            r_stat <= STAT_DONE;
            r_top  <= '0;
        end
        if (i_cmd.ins_drop) begin
            r_stat <= STAT_FULL;
            r_top  <= '0;
        end
        if (i_cmd.pop_empty) begin
            r_stat <= STAT_EMPTY;
            r_top  <= '0;
        end
        if (i_cmd.pop_root) begin
            r_stat <= STAT_DONE;
        end
        if (i_cmd.pop_last) begin
            r_top <= rdata.id;
        end
        if (i_cmd.pop_load) begin
            r_cur <= rdata;
            r_pos <= CW'(1);
        end
        if (i_cmd.su_cmp && o_status.su_swap) begin
            r_pos <= parent;
        end
        if (i_cmd.sd_rdr) begin
            r_left        <= rdata;
            r_left_better <= rd_vs_cur;
        end
        if (i_cmd.sd_cmp && o_status.sd_swap) begin
            r_pos <= pick_right ? {child[CW-1:1], 1'b1} : child[CW-1:0];
        end
    end

    assign occ_ext         = {{OCC_W{1'b0}}, r_count};
    assign o_rsp.status    = r_stat;
    assign o_rsp.top_id    = r_top;
    assign o_rsp.occupancy = occ_ext[OCC_W-1:0];

endmodule

// ----- rtl/binary_heap_priority_queue_core.sv -----
// Top level of the binary heap priority queue core.
`timescale 1ns / 1ps
// Insert sifts the new entry up toward the root; pop moves the last entry to the root
// and sifts it down until it stops or reaches a leaf; a dropped insert or an empty pop
// goes straight to the response.
// One request at a time: busy stays high while the walk through the entry RAM runs.
// o_done pulses once and cannot be stalled; i_rst_n (sync, active low) empties the heap.
module binary_heap_priority_queue_core
    import bhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Request transfer: taken when start is high and busy is low.
    input  logic start,
    output logic busy,
    input  t_req i_req,
    // Result transfer: one cycle, marked by o_done.
    output logic o_done,
    output t_rsp o_rsp,
    // Order select: 1 keeps the smallest priority on top.
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // Sequence each request: decode at the start transfer, then walk the heap.
    bhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_status   (dp_status),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    // Hold the moving entry in a register and write each displaced entry
    // back once, so every heap level costs one write, one read going up and two going down.
    bhpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_status    (dp_status),
        .o_rsp       (o_rsp)
    );

endmodule
